FILE: hw/rtl/mtg_pkg.sv
package mtg_pkg;

  // generator geometry
  localparam int STATE_WORDS   = 624;
  localparam int MIDDLE_OFFSET = 397;
  localparam int ADDR_W        = $clog2(STATE_WORDS);
  // read index also holds the "regenerate" and "unseeded" marks
  localparam int IDX_W         = $clog2(STATE_WORDS + 2);

  // field widths
  localparam int WORD_W  = 32;
  localparam int COUNT_W = 7;
  localparam int PADDR_W = 3;

  // longest run of words for one request
  localparam logic [COUNT_W-1:0] MAX_RUN = COUNT_W'(64);

  // recurrence and tempering constants
  localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908_b0df;
  localparam logic [WORD_W-1:0] SEED_MULT    = 32'd1812433253;
  localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c_5680;
  localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc6_0000;
  localparam logic [WORD_W-1:0] SEED_RESET   = 32'd5489;

  // register index of the seed word (word address bit 2)
  localparam logic REG_SEED = 1'b0;

  // store write data select
  typedef logic [1:0] wsel_t;
  localparam wsel_t WSEL_SEED  = 2'd0;
  localparam wsel_t WSEL_KNUTH = 2'd1;
  localparam wsel_t WSEL_TWIST = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr_a;
    logic [ADDR_W-1:0] rd_addr_b;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    wsel_t             wr_sel;
    logic              mul_en;
    logic              cur_load;
    logic              out_load;
    logic              out_last;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic slot_free;
  } sts_t;

endpackage

FILE: hw/rtl/mtg_in_if.sv
interface mtg_in_if;
  logic                          valid;
  logic                          ready;
  logic [mtg_pkg::COUNT_W-1:0]   word_count;

  modport source (output valid, output word_count, input ready);
  modport sink   (input valid, input word_count, output ready);
endinterface

FILE: hw/rtl/mtg_out_if.sv
interface mtg_out_if;
  logic                         valid;
  logic                         ready;
  logic [mtg_pkg::WORD_W-1:0]   random_word;
  logic                         last;

  modport source (output valid, output random_word, output last, input ready);
  modport sink   (input valid, input random_word, input last, output ready);
endinterface

FILE: hw/rtl/mtg_ram.sv
module mtg_ram #(
  parameter int WIDTH = mtg_pkg::WORD_W,
  parameter int DEPTH = mtg_pkg::STATE_WORDS
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, two registered read ports; read data holds when idle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

FILE: hw/rtl/mtg_datapath.sv
module mtg_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  mtg_pkg::cmd_t                cmd,
  output mtg_pkg::sts_t                sts,
  input  logic                         cfg_wr,
  input  logic [mtg_pkg::WORD_W-1:0]   cfg_wdata,
  output logic [mtg_pkg::WORD_W-1:0]   seed,
  mtg_out_if.source                    out_ch
);

  logic [mtg_pkg::WORD_W-1:0] seed_r;
  logic [mtg_pkg::WORD_W-1:0] p_r, p_nxt;
  logic [mtg_pkg::WORD_W-1:0] prod_r;
  logic [mtg_pkg::WORD_W-1:0] cur_r;
  logic [mtg_pkg::WORD_W-1:0] rd_a, rd_b;
  logic [mtg_pkg::WORD_W-1:0] wdata;
  logic [mtg_pkg::WORD_W-1:0] knuth_val, twist_val, mix;
  logic [mtg_pkg::WORD_W-1:0] y;
  logic [mtg_pkg::WORD_W-1:0] t1, t2, t3, t4;
  logic                       out_valid_r, out_valid_nxt;
  logic [mtg_pkg::WORD_W-1:0] out_word_r;
  logic                       out_last_r;

  // state store
  mtg_ram #(
    .WIDTH (mtg_pkg::WORD_W),
    .DEPTH (mtg_pkg::STATE_WORDS)
  ) u_store (
    .clk     (clk),
    .we      (cmd.wr_en),
    .waddr   (cmd.wr_addr),
    .wdata   (wdata),
    .re      (cmd.rd_en),
    .raddr_a (cmd.rd_addr_a),
    .raddr_b (cmd.rd_addr_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  // seed register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= mtg_pkg::SEED_RESET;
    end else if (cfg_wr) begin
      seed_r <= cfg_wdata;
    end
  end

  assign seed = seed_r;

  // knuth seeding term and twist recurrence
  assign mix       = p_r ^ (p_r >> 30);
  assign knuth_val = prod_r + mtg_pkg::WORD_W'(cmd.wr_addr);
  assign y         = {cur_r[mtg_pkg::WORD_W-1], rd_a[mtg_pkg::WORD_W-2:0]};
  assign twist_val = rd_b ^ (y >> 1) ^ (y[0] ? mtg_pkg::TWIST_MATRIX : '0);

  // store write data select
  always_comb begin
    case (cmd.wr_sel)
      mtg_pkg::WSEL_SEED:  wdata = seed_r;
      mtg_pkg::WSEL_KNUTH: wdata = knuth_val;
      mtg_pkg::WSEL_TWIST: wdata = twist_val;
      default:             wdata = twist_val;
    endcase
  end

  // previous seeded word follows each seeding write
  always_comb begin
    p_nxt = p_r;
    if (cmd.wr_en && (cmd.wr_sel == mtg_pkg::WSEL_SEED || cmd.wr_sel == mtg_pkg::WSEL_KNUTH)) begin
      p_nxt = wdata;
    end
  end

  // seeding multiplier and twist current word
  always_ff @(posedge clk) begin
    p_r <= p_nxt;
    if (cmd.mul_en) begin
      prod_r <= mix * mtg_pkg::SEED_MULT;
    end
    if (cmd.cur_load) begin
      cur_r <= rd_a;
    end
  end

  // tempering
  assign t1 = rd_a ^ (rd_a >> 11);
  assign t2 = t1 ^ ((t1 << 7) & mtg_pkg::TEMPER_B);
  assign t3 = t2 ^ ((t2 << 15) & mtg_pkg::TEMPER_C);
  assign t4 = t3 ^ (t3 >> 18);

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_word_r <= t4;
      out_last_r <= cmd.out_last;
    end
  end

  assign sts.slot_free      = !out_valid_r || out_ch.ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.random_word = out_word_r;
  assign out_ch.last        = out_last_r;

endmodule

FILE: hw/rtl/mtg_ctrl.sv
module mtg_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  mtg_in_if.sink        in_ch,
  input  logic          seed_wr,
  output mtg_pkg::cmd_t cmd,
  input  mtg_pkg::sts_t sts
);

  localparam int AW = mtg_pkg::ADDR_W;
  localparam int IW = mtg_pkg::IDX_W;
  localparam int CW = mtg_pkg::COUNT_W;
  localparam logic [AW-1:0] K_LAST   = AW'(mtg_pkg::STATE_WORDS - 1);
  localparam logic [AW-1:0] MID_WRAP = AW'(mtg_pkg::STATE_WORDS - mtg_pkg::MIDDLE_OFFSET);
  localparam logic [AW-1:0] MID_OFS  = AW'(mtg_pkg::MIDDLE_OFFSET);
  localparam logic [IW-1:0] IDX_REGEN    = IW'(mtg_pkg::STATE_WORDS);
  localparam logic [IW-1:0] IDX_UNSEEDED = IW'(mtg_pkg::STATE_WORDS + 1);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_GEN_RD   = 4'd1;
  localparam logic [3:0] S_GEN_LD   = 4'd2;
  localparam logic [3:0] S_SEED0    = 4'd3;
  localparam logic [3:0] S_SEED_MUL = 4'd4;
  localparam logic [3:0] S_SEED_WR  = 4'd5;
  localparam logic [3:0] S_TW_PRIME = 4'd6;
  localparam logic [3:0] S_TW_RD    = 4'd7;
  localparam logic [3:0] S_TW_WR    = 4'd8;

  logic [3:0]    state_r, state_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [AW-1:0] k_r, k_nxt;
  logic [CW-1:0] rem_r, rem_nxt;
  logic [AW-1:0] k_next_addr, k_mid_addr;

  // neighbor and middle addresses of the twist step
  assign k_next_addr = (k_r == K_LAST) ? '0 : k_r + AW'(1);
  assign k_mid_addr  = (k_r < MID_WRAP) ? k_r + MID_OFS : k_r - MID_WRAP;

  assign in_ch.ready = (state_r == S_IDLE);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    k_nxt         = k_r;
    rem_nxt       = rem_r;
    cmd           = '0;
    cmd.wr_sel    = mtg_pkg::WSEL_TWIST;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid && in_ch.word_count != '0) begin
          rem_nxt   = (in_ch.word_count > mtg_pkg::MAX_RUN) ? mtg_pkg::MAX_RUN
                                                              : in_ch.word_count;
          state_nxt = S_GEN_RD;
        end
      end
      S_GEN_RD: begin
        if (idx_r > IDX_REGEN) begin
          state_nxt = S_SEED0;
        end else if (idx_r == IDX_REGEN) begin
          state_nxt = S_TW_PRIME;
        end else begin
          cmd.rd_en     = 1'b1;
          cmd.rd_addr_a = idx_r[AW-1:0];
          idx_nxt       = idx_r + IW'(1);
          state_nxt     = S_GEN_LD;
        end
      end
      S_GEN_LD: begin
        if (sts.slot_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = (rem_r == CW'(1));
          rem_nxt      = rem_r - CW'(1);
          if (rem_r == CW'(1)) begin
            state_nxt = S_IDLE;
          end else if (idx_r < IDX_REGEN) begin
            // fetch the next word while this one goes out
            cmd.rd_en     = 1'b1;
            cmd.rd_addr_a = idx_r[AW-1:0];
            idx_nxt       = idx_r + IW'(1);
          end else begin
            state_nxt = S_GEN_RD;
          end
        end
      end
      S_SEED0: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_addr = '0;
        cmd.wr_sel  = mtg_pkg::WSEL_SEED;
        k_nxt       = AW'(1);
        state_nxt   = S_SEED_MUL;
      end
      S_SEED_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = S_SEED_WR;
      end
      S_SEED_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_addr = k_r;
        cmd.wr_sel  = mtg_pkg::WSEL_KNUTH;
        if (k_r == K_LAST) begin
          idx_nxt   = IDX_REGEN;
          state_nxt = S_TW_PRIME;
        end else begin
          k_nxt     = k_r + AW'(1);
          state_nxt = S_SEED_MUL;
        end
      end
      S_TW_PRIME: begin
        cmd.rd_en     = 1'b1;
        cmd.rd_addr_a = '0;
        k_nxt         = '0;
        state_nxt     = S_TW_RD;
      end
      S_TW_RD: begin
        cmd.cur_load  = 1'b1;
        cmd.rd_en     = 1'b1;
        cmd.rd_addr_a = k_next_addr;
        cmd.rd_addr_b = k_mid_addr;
        state_nxt     = S_TW_WR;
      end
      S_TW_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_addr = k_r;
        cmd.wr_sel  = mtg_pkg::WSEL_TWIST;
        if (k_r == K_LAST) begin
          idx_nxt   = '0;
          state_nxt = S_GEN_RD;
        end else begin
          k_nxt     = k_r + AW'(1);
          state_nxt = S_TW_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    // a new seed restarts the sequence
    if (seed_wr) begin
      idx_nxt = IDX_UNSEEDED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= IDX_UNSEEDED;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r   <= k_nxt;
    rem_r <= rem_nxt;
  end

`ifndef SYNTH
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= IDX_UNSEEDED)
    else $error("read index out of range");

  a_word_read_in_store: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rd_en && (state_r == S_GEN_RD || state_r == S_GEN_LD)) |-> idx_r < IDX_REGEN)
    else $error("word read past end of store");

  a_load_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.slot_free)
    else $error("output register overwritten");

  a_run_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_GEN_RD || state_r == S_GEN_LD) |-> rem_r != '0)
    else $error("run active with no words left");

  a_run_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load && cmd.out_last) |=> state_r == S_IDLE)
    else $error("run did not end after last word");
`endif

endmodule

FILE: hw/rtl/mersenne_twister_generator.sv
// channel   direction  handshake        payload
// in_ch     sink       valid / ready    word_count[6:0]
// out_ch    source     valid / ready    random_word[31:0], last
// apb       slave      psel / penable   seed at address 0 (pready tied high)
//
// a request is taken in idle; words then go out at one per cycle while the output
// accepts them, apart from the stops for regeneration and for the start of each
// request
// regeneration (twist) over the 624-word store runs once every 624 words;
// for each word it reads the neighbor and middle words, then writes the new word
// after reset or a seed write the store is rebuilt before the first word: seeding
// (one multiply and one write per word), then a twist
// a stalled output holds its word; the next word waits in the store read register

module mersenne_twister_generator (
  input  logic                          clk,
  input  logic                          rst_n,
  mtg_in_if.sink                        in_ch,
  mtg_out_if.source                     out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mtg_pkg::PADDR_W-1:0]   paddr,
  input  logic [mtg_pkg::WORD_W-1:0]    pwdata,
  output logic [mtg_pkg::WORD_W-1:0]    prdata,
  output logic                          pready
);

  mtg_pkg::cmd_t              cmd;
  mtg_pkg::sts_t              sts;
  logic                       seed_wr;
  logic [mtg_pkg::WORD_W-1:0] seed;

  // register decode
  assign pready  = 1'b1;
  assign seed_wr = psel && penable && pwrite && (paddr[2] == mtg_pkg::REG_SEED);
  assign prdata  = (paddr[2] == mtg_pkg::REG_SEED) ? seed : '0;

  mtg_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .seed_wr (seed_wr),
    .cmd     (cmd),
    .sts     (sts)
  );

  mtg_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_wr    (seed_wr),
    .cfg_wdata (pwdata),
    .seed      (seed),
    .out_ch    (out_ch)
  );

endmodule

FILE: tb/mersenne_twister_generator_tb.sv
module mersenne_twister_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // quiet cycles after the last word before the generator counts as idle
  localparam int unsigned DRAIN_TAIL   = 16;
  localparam int unsigned RANDOM_ITEMS = 200;
  localparam logic [mtg_pkg::PADDR_W-1:0] SEED_ADDR = {mtg_pkg::REG_SEED, 2'b00};

  typedef enum logic {ROW_REQ, ROW_SEED} row_kind_t;

  typedef struct {
    row_kind_t kind;
    bit [31:0] value;
    bit        typed;
    bit [31:0] word;
  } stim_row_t;

  typedef struct {
    logic [mtg_pkg::WORD_W-1:0] word;
    logic                       last;
  } word_exp_t;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [mtg_pkg::PADDR_W-1:0] paddr;
  logic [mtg_pkg::WORD_W-1:0]  pwdata;
  logic [mtg_pkg::WORD_W-1:0]  prdata;
  logic pready;

  mtg_in_if  in_ch ();
  mtg_out_if out_ch ();

  mersenne_twister_generator u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // generator mirror: seed, state words and read position
  logic [mtg_pkg::WORD_W-1:0] seed_word = mtg_pkg::SEED_RESET;
  logic [mtg_pkg::WORD_W-1:0] mt_state [mtg_pkg::STATE_WORDS];
  int unsigned                mt_pos = mtg_pkg::STATE_WORDS + 1;

  word_exp_t pending_words [$];
  int unsigned err_count = 0;
  bit pace_on = 1'b1;

  // directed requests and seed changes; typed words are the well-known seed 5489 outputs
  stim_row_t dir_rows [25] = '{
    '{ROW_REQ,  32'd1,          1'b1, 32'd3499211612},
    '{ROW_REQ,  32'd1,          1'b1, 32'd581869302},
    '{ROW_REQ,  32'd0,          1'b0, 32'd0},
    '{ROW_REQ,  32'd64,         1'b0, 32'd0},
    '{ROW_REQ,  32'd65,         1'b0, 32'd0},
    '{ROW_REQ,  32'd127,        1'b0, 32'd0},
    '{ROW_REQ,  32'd2,          1'b0, 32'd0},
    '{ROW_SEED, 32'h0000_0000,  1'b0, 32'd0},
    '{ROW_REQ,  32'd1,          1'b0, 32'd0},
    '{ROW_REQ,  32'd7,          1'b0, 32'd0},
    '{ROW_SEED, 32'hffff_ffff,  1'b0, 32'd0},
    '{ROW_REQ,  32'd100,        1'b0, 32'd0},
    '{ROW_REQ,  32'd64,         1'b0, 32'd0},
    '{ROW_REQ,  32'd64,         1'b0, 32'd0},
    '{ROW_REQ,  32'd64,         1'b0, 32'd0},
    '{ROW_REQ,  32'd64,         1'b0, 32'd0},
    '{ROW_REQ,  32'd64,         1'b0, 32'd0},
    '{ROW_REQ,  32'd64,         1'b0, 32'd0},
    '{ROW_REQ,  32'd64,         1'b0, 32'd0},
    '{ROW_REQ,  32'd64,         1'b0, 32'd0},
    '{ROW_REQ,  32'd127,        1'b0, 32'd0},
    '{ROW_SEED, 32'd5489,       1'b0, 32'd0},
    '{ROW_REQ,  32'd1,          1'b1, 32'd3499211612},
    '{ROW_REQ,  32'd0,          1'b0, 32'd0},
    '{ROW_REQ,  32'd1,          1'b1, 32'd581869302}
  };

  // next tempered word: seed the store when unseeded, twist when used up
  function automatic logic [mtg_pkg::WORD_W-1:0] next_random();
    logic [mtg_pkg::WORD_W-1:0] y;
    int unsigned nxt;
    int unsigned mid;
    if (mt_pos > mtg_pkg::STATE_WORDS) begin
      mt_state[0] = seed_word;
      for (int i = 1; i < mtg_pkg::STATE_WORDS; i++) begin
        y = mt_state[i-1];
        mt_state[i] = mtg_pkg::SEED_MULT * (y ^ (y >> 30)) + mtg_pkg::WORD_W'(i);
      end
      mt_pos = mtg_pkg::STATE_WORDS;
    end
    if (mt_pos == mtg_pkg::STATE_WORDS) begin
      for (int k = 0; k < mtg_pkg::STATE_WORDS; k++) begin
        nxt = (k + 1) % mtg_pkg::STATE_WORDS;
        mid = (k + mtg_pkg::MIDDLE_OFFSET) % mtg_pkg::STATE_WORDS;
        y = {mt_state[k][mtg_pkg::WORD_W-1], mt_state[nxt][mtg_pkg::WORD_W-2:0]};
        mt_state[k] = mt_state[mid] ^ (y >> 1) ^ (y[0] ? mtg_pkg::TWIST_MATRIX : '0);
      end
      mt_pos = 0;
    end
    y = mt_state[mt_pos];
    mt_pos++;
    y ^= (y >> 11);
    y ^= (y << 7) & mtg_pkg::TEMPER_B;
    y ^= (y << 15) & mtg_pkg::TEMPER_C;
    y ^= (y >> 18);
    return y;
  endfunction

  // idle length: mostly short, a few long, none when pacing is off
  function automatic int unsigned idle_len(input bit may_skip);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!pace_on) return 0;
    if (may_skip && r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // one request transfer, then queue the words it should produce
  task automatic send_request(input logic [mtg_pkg::COUNT_W-1:0] cnt, input bit typed,
                              input logic [mtg_pkg::WORD_W-1:0] typed_word);
    int unsigned gap;
    int unsigned n;
    word_exp_t e;
    gap = idle_len(1'b1);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.word_count <= cnt;
    do @(posedge clk); while (!in_ch.ready);
    n = (cnt > mtg_pkg::MAX_RUN) ? mtg_pkg::MAX_RUN : cnt;
    for (int k = 0; k < n; k++) begin
      e.word = next_random();
      e.last = (k + 1 == n);
      if (typed && k == 0) e.word = typed_word;
      pending_words.push_back(e);
    end
  endtask

  // hold requests until every queued word has come out
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  task automatic apb_read(output logic [mtg_pkg::WORD_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= SEED_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // new seed while idle, then read it back
  task automatic program_seed(input logic [mtg_pkg::WORD_W-1:0] value);
    logic [mtg_pkg::WORD_W-1:0] rd;
    drain_results();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= SEED_ADDR;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    seed_word = value;
    mt_pos    = mtg_pkg::STATE_WORDS + 1;
    @(posedge clk);
    apb_read(rd);
    if (rd !== value) begin
      err_count++;
      $display("%0t: seed readback expected %h actual %h", $time, value, rd);
    end
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #40ms;
    $display("TB_ERROR");
    $finish;
  end

  // result side: random stalls of ready
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (pace_on && $urandom_range(0, 2) == 0) begin
        out_ch.ready <= 1'b0;
        repeat (idle_len(1'b0) + 1) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // compare each result transfer with the oldest queued word
  always @(posedge clk) begin
    word_exp_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_words.size() == 0) begin
        err_count++;
        $display("%0t: unexpected word, expected none actual %h last %b",
                 $time, out_ch.random_word, out_ch.last);
      end else begin
        e = pending_words.pop_front();
        if (out_ch.random_word !== e.word) begin
          err_count++;
          $display("%0t: random_word expected %h actual %h",
                   $time, e.word, out_ch.random_word);
        end
        if (out_ch.last !== e.last) begin
          err_count++;
          $display("%0t: last expected %b actual %b", $time, e.last, out_ch.last);
        end
      end
    end
  end

  // stimulus
  initial begin
    logic [mtg_pkg::WORD_W-1:0] rd;
    logic [mtg_pkg::COUNT_W-1:0] cnt;
    int unsigned r;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.word_count <= '0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // seed register after reset
    apb_read(rd);
    if (rd !== mtg_pkg::SEED_RESET) begin
      err_count++;
      $display("%0t: reset seed expected %h actual %h", $time, mtg_pkg::SEED_RESET, rd);
    end

    // directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_SEED)
        program_seed(dir_rows[i].value);
      else
        send_request(mtg_pkg::COUNT_W'(dir_rows[i].value), dir_rows[i].typed,
                     dir_rows[i].word);
    end

    // random requests, with a stretch of back-to-back traffic in the middle
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pace_on = !(n >= 80 && n < 120);
      if (n == 49 || n == 149)
        program_seed($urandom());
      else if (n == 99)
        program_seed(32'h0000_0001);
      else if (n == 125)
        drain_results();
      r = $urandom_range(0, 99);
      if (r < 5)
        cnt = '0;
      else if (r < 10)
        cnt = mtg_pkg::COUNT_W'($urandom_range(65, 127));
      else if (r < 75)
        cnt = mtg_pkg::COUNT_W'($urandom_range(1, 16));
      else
        cnt = mtg_pkg::COUNT_W'($urandom_range(17, 64));
      send_request(cnt, 1'b0, '0);
    end

    drain_results();
    if (err_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/mtg_pkg.sv
hw/rtl/mtg_in_if.sv
hw/rtl/mtg_out_if.sv
hw/rtl/mtg_ram.sv
hw/rtl/mtg_datapath.sv
hw/rtl/mtg_ctrl.sv
hw/rtl/mersenne_twister_generator.sv
tb/mersenne_twister_generator_tb.sv
